@@ rtl/core/psc_pkg.sv @@
package psc_pkg;

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_INSERT = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_MISS   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		MODE_UNINIT = 2'd0,
		MODE_MONO   = 2'd1,
		MODE_POLY   = 2'd2,
		MODE_MEGA   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	localparam logic REG_POLY_LIMIT = 1'b0;
	localparam logic REG_MISS_LIMIT = 1'b1;

	localparam logic [4:0]  POLY_LIMIT_RST = 5'd9;
	localparam logic [15:0] MISS_LIMIT_RST = 16'd10;
	localparam logic [15:0] MISS_MAX       = 16'hFFFF;

	typedef struct packed {
		logic [4:0]  poly_limit;
		logic [15:0] miss_limit;
	} cfg_t;

	typedef struct packed {
		logic [63:0] key;
		logic [31:0] slot;
		logic        inl;
	} entry_t;

	typedef struct packed {
		logic        hit;
		logic [31:0] hit_slot;
		logic        hit_inline;
		logic [1:0]  mode;
		logic        dropped;
	} result_t;

endpackage

@@ rtl/core/polymorphic_shape_cache.sv @@
// shape-keyed inline cache for one access site
// input channel: in_valid/in_stall with func, shape, slot, inline_flag;
//   func selects lookup, insert, clear or record-miss
// output channel: out_valid/out_stall with hit, hit_slot, hit_inline,
//   mode and dropped; exactly one result word per input word, in order
// config: apb write to poly_limit at 0x0 and miss_limit at 0x4, pready tied high
// entries sit in one synchronous ram searched one entry per cycle; a
//   lookup or insert scans from entry 0 until a match or the last entry
//   and then reaches the done state; clear and record-miss go from idle
//   straight to the done state
// one word is in flight at a time; in_stall is high from accept until the
//   result is moved into the output register, and the next word can be
//   accepted on the following cycle
// the output register holds a result while out_stall is high; the next input
//   word is accepted meanwhile and waits at its final step until the
//   register frees up
// reset empties the table, clears mode and miss count, loads the limit
//   registers with 9 and 10 and drops any pending result; no ram clearing pass
module polymorphic_shape_cache #(
	parameter int DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [63:0] shape,
	input  logic [31:0] slot,
	input  logic        inline_flag,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        hit,
	output logic [31:0] hit_slot,
	output logic        hit_inline,
	output logic [1:0]  mode,
	output logic        dropped,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	psc_pkg::cfg_t    cfg;
	psc_pkg::result_t res;
	psc_pkg::result_t out_res_q;
	logic             out_valid_q;
	logic             out_free;
	logic             busy;
	logic             done;
	logic             start;

	assign in_stall = busy;
	assign start    = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	psc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	psc_core #(
		.DEPTH (DEPTH)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.op          (psc_pkg::op_t'(func)),
		.shape       (shape),
		.slot        (slot),
		.inline_flag (inline_flag),
		.cfg         (cfg),
		.out_free    (out_free),
		.busy        (busy),
		.done        (done),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done)
			out_res_q <= res;
	end

	assign out_valid  = out_valid_q;
	assign hit        = out_res_q.hit;
	assign hit_slot   = out_res_q.hit_slot;
	assign hit_inline = out_res_q.hit_inline;
	assign mode       = out_res_q.mode;
	assign dropped    = out_res_q.dropped;

endmodule

@@ rtl/core/psc_regs.sv @@
module psc_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output psc_pkg::cfg_t     cfg
);

	psc_pkg::cfg_t cfg_q;
	logic          wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.poly_limit <= psc_pkg::POLY_LIMIT_RST;
			cfg_q.miss_limit <= psc_pkg::MISS_LIMIT_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				psc_pkg::REG_POLY_LIMIT: cfg_q.poly_limit <= pwdata[4:0];
				psc_pkg::REG_MISS_LIMIT: cfg_q.miss_limit <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			psc_pkg::REG_POLY_LIMIT: prdata = {27'd0, cfg_q.poly_limit};
			psc_pkg::REG_MISS_LIMIT: prdata = {16'd0, cfg_q.miss_limit};
			default: prdata = '0;
		endcase
	end

endmodule

@@ rtl/core/psc_core.sv @@
module psc_core #(
	parameter int DEPTH,
	localparam int IW   = $clog2(DEPTH),
	localparam int CW   = $clog2(DEPTH + 1),
	localparam int CMPW = (CW > 5) ? CW : 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  psc_pkg::op_t       op,
	input  logic [63:0]        shape,
	input  logic [31:0]        slot,
	input  logic               inline_flag,
	input  psc_pkg::cfg_t      cfg,
	input  logic               out_free,
	output logic               busy,
	output logic               done,
	output psc_pkg::result_t   res
);

	psc_pkg::entry_t mem [DEPTH];

	psc_pkg::state_t state_q, state_nxt;
	psc_pkg::op_t    op_q;
	logic [63:0]     shape_q;
	logic [31:0]     slot_q;
	logic            inl_q;

	logic [CW-1:0]   cnt_q, cnt_nxt;
	psc_pkg::mode_t  mode_q, mode_nxt;
	logic [15:0]     miss_q, miss_nxt;

	logic [CW-1:0]   rd_idx_q;
	logic            rd_en;
	logic            rd_valid_s1;
	logic [IW-1:0]   cmp_idx_s1;
	psc_pkg::entry_t rdata_s1;
	logic            match_now;

	logic            found_q;
	logic [IW-1:0]   found_idx_q;
	logic [31:0]     found_slot_q;
	logic            found_inl_q;

	logic            wr_en;
	logic [IW-1:0]   wr_addr;
	psc_pkg::entry_t wr_data;
	logic            full;
	logic [CW-1:0]   new_cnt;
	logic [15:0]     miss_inc;

	assign match_now = rd_valid_s1 && (rdata_s1.key == shape_q);
	assign rd_en     = (state_q == psc_pkg::ST_SCAN) && (rd_idx_q < cnt_q) && !match_now;
	assign busy      = state_q != psc_pkg::ST_IDLE;
	assign done      = (state_q == psc_pkg::ST_DONE) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= psc_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			psc_pkg::ST_IDLE: begin
				if (start) begin
					if (op inside {psc_pkg::OP_LOOKUP, psc_pkg::OP_INSERT})
						state_nxt = psc_pkg::ST_SCAN;
					else
						state_nxt = psc_pkg::ST_DONE;
				end
			end
			psc_pkg::ST_SCAN: begin
				if (match_now || (!rd_en && !rd_valid_s1))
					state_nxt = psc_pkg::ST_DONE;
			end
			psc_pkg::ST_DONE: begin
				if (out_free)
					state_nxt = psc_pkg::ST_IDLE;
			end
			default: state_nxt = psc_pkg::ST_IDLE;
		endcase
	end

	// item capture
	always_ff @(posedge clk) begin
		if (start) begin
			op_q    <= op;
			shape_q <= shape;
			slot_q  <= slot;
			inl_q   <= inline_flag;
		end
	end

	// scan pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q    <= '0;
			rd_valid_s1 <= 1'b0;
			found_q     <= 1'b0;
		end else if (start) begin
			rd_idx_q    <= '0;
			rd_valid_s1 <= 1'b0;
			found_q     <= 1'b0;
		end else if (state_q == psc_pkg::ST_SCAN) begin
			rd_valid_s1 <= rd_en;
			if (rd_en)
				rd_idx_q <= rd_idx_q + 1'b1;
			if (match_now)
				found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			cmp_idx_s1 <= rd_idx_q[IW-1:0];
		if ((state_q == psc_pkg::ST_SCAN) && match_now) begin
			found_idx_q  <= cmp_idx_s1;
			found_slot_q <= rdata_s1.slot;
			found_inl_q  <= rdata_s1.inl;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rdata_s1 <= mem[rd_idx_q[IW-1:0]];
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	// result and update
	assign full     = cnt_q == CW'(DEPTH);
	assign new_cnt  = cnt_q + 1'b1;
	assign miss_inc = (miss_q != psc_pkg::MISS_MAX) ? miss_q + 16'd1 : miss_q;

	always_comb begin
		res          = '0;
		cnt_nxt      = cnt_q;
		mode_nxt     = mode_q;
		miss_nxt     = miss_q;
		wr_en        = 1'b0;
		wr_addr      = found_idx_q;
		wr_data.key  = shape_q;
		wr_data.slot = slot_q;
		wr_data.inl  = inl_q;
		unique case (op_q)
			psc_pkg::OP_LOOKUP: begin
				res.hit        = found_q;
				res.hit_slot   = found_q ? found_slot_q : 32'd0;
				res.hit_inline = found_q && found_inl_q;
			end
			psc_pkg::OP_INSERT: begin
				if (found_q) begin
					wr_en = done;
				end else if (!full) begin
					wr_en   = done;
					wr_addr = cnt_q[IW-1:0];
					cnt_nxt = new_cnt;
					if (new_cnt == CW'(1))
						mode_nxt = psc_pkg::MODE_MONO;
					else if (CMPW'(new_cnt) < CMPW'(cfg.poly_limit))
						mode_nxt = psc_pkg::MODE_POLY;
					else
						mode_nxt = psc_pkg::MODE_MEGA;
				end else begin
					res.dropped = 1'b1;
				end
			end
			psc_pkg::OP_CLEAR: begin
				cnt_nxt  = '0;
				mode_nxt = psc_pkg::MODE_UNINIT;
				miss_nxt = '0;
			end
			psc_pkg::OP_MISS: begin
				miss_nxt = miss_inc;
				if (miss_inc > cfg.miss_limit)
					mode_nxt = psc_pkg::MODE_MEGA;
			end
			default: ;
		endcase
		res.mode = mode_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			mode_q <= psc_pkg::MODE_UNINIT;
			miss_q <= '0;
		end else if (done) begin
			cnt_q  <= cnt_nxt;
			mode_q <= mode_nxt;
			miss_q <= miss_nxt;
		end
	end

endmodule

@@ rtl/core/psc_checker.sv @@
module psc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        hit,
	input logic [31:0] hit_slot,
	input logic        hit_inline,
	input logic [1:0]  mode,
	input logic        dropped
);

	// one word in flight: accept is followed by stall
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a word is in flight");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(hit_slot) && $stable(mode))
		else $error("stalled result word changed");

	// a hit needs a non-empty table, so mode cannot be uninitialized
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> mode != psc_pkg::MODE_UNINIT && !dropped)
		else $error("hit with uninitialized mode");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dropped |-> !hit && mode != psc_pkg::MODE_UNINIT)
		else $error("drop without a full table");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> hit_slot == 32'd0 && !hit_inline)
		else $error("miss carries entry data");

endmodule

bind polymorphic_shape_cache psc_checker u_psc_checker (.*);
